[rtl/tldp_pkg.sv]
// Shared types, constants and helper functions for the two-level direction predictor.
package tldp_pkg;

	localparam int HIST_W = 12;  // stored history register width
	localparam int CTR_W  = 2;   // saturating counter width
	localparam int IDX_W  = 12;  // counter index field width
	localparam int HB_W   = 4;   // history_bits register width
	localparam int HB_MAX = 12;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	localparam logic CFG_XOR_MODE     = 1'b0;
	localparam logic CFG_HISTORY_BITS = 1'b1;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HIST  = 5'b00100,
		S_CTR   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	// history length actually used: 0 acts as 1, above 12 acts as 12
	function automatic logic [HB_W-1:0] eff_hbits(input logic [HB_W-1:0] hb);
		logic [HB_W-1:0] r;
		begin
			if (hb == '0) begin
				r = HB_W'(1);
			end else if (hb > HB_W'(HB_MAX)) begin
				r = HB_W'(HB_MAX);
			end else begin
				r = hb;
			end
			return r;
		end
	endfunction

	// two-bit saturating step
	function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] c, input logic tk);
		logic [CTR_W-1:0] r;
		begin
			r = c;
			if (tk) begin
				if (c != '1) begin
					r = c + CTR_W'(1);
				end
			end else begin
				if (c != '0) begin
					r = c - CTR_W'(1);
				end
			end
			return r;
		end
	endfunction

endpackage

[rtl/tldp_ram.sv]
// Single-port synchronous RAM with registered read.
module tldp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[rtl/two_level_branch_direction_predictor.sv]
// Flow: a conditional request reads the history table, then the counter table, then
// moves its result to the output register; an unconditional one goes straight to the
// result. The output register then holds the result until taken. A new request is
// accepted only once the last result has been loaded, as the two single-port RAMs serialise.
// Reset: asynchronous, active low; afterwards a clearing pass over max(HISTORY_ENTRIES,
// COUNTER_ENTRIES) entries (4096 by default) initialises both tables before any request.
module two_level_branch_direction_predictor
	import tldp_pkg::*;
#(
	parameter int HISTORY_ENTRIES = 1024,  // power of two
	parameter int COUNTER_ENTRIES = 4096,  // power of two
	parameter int ADDR_SHIFT      = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [31:0]       branch_addr,
	input  logic              is_conditional,
	input  logic              taken,
	input  logic [IDX_W-1:0]  update_index,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic              dir_taken,
	output logic [IDX_W-1:0]  counter_index,
	// configuration
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [HB_W-1:0]   cfg_wdata
);

	localparam int HAW  = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;
	localparam int CW   = $clog2(COUNTER_ENTRIES);
	localparam int MAXE = (HISTORY_ENTRIES > COUNTER_ENTRIES) ? HISTORY_ENTRIES
	                                                          : COUNTER_ENTRIES;
	localparam int CLRW = $clog2(MAXE);

	state_t state_q;

	// configuration registers
	logic            xor_mode_q;
	logic [HB_W-1:0] history_bits_q;

	// clearing pass counter
	logic [CLRW-1:0] clr_q;

	// held request
	logic            cmd_q;
	logic [31:0]     branch_addr_q;
	logic            cond_q;
	logic            taken_q;
	logic [IDX_W-1:0] update_index_q;
	logic [CW-1:0]   idx_q;

	// finished result waiting for the output register
	logic            res_pred_q;
	logic [IDX_W-1:0] res_idx_q;

	// RAM ports
	logic              h_en, h_we;
	logic [HAW-1:0]    h_addr;
	logic [HIST_W-1:0] h_wdata, h_rdata;
	logic              c_en, c_we;
	logic [CW-1:0]     c_addr;
	logic [CTR_W-1:0]  c_wdata, c_rdata;

	logic              in_acc;
	logic              out_load;
	logic              clr_last;
	logic              clr_h_ok, clr_c_ok;
	logic [31:0]       a_in, a_q;
	logic [HAW-1:0]    hs_in, hs_q;
	logic [HB_W-1:0]   hb;
	logic [HIST_W-1:0] hmask;
	logic [31:0]       idx_full;
	logic [CW-1:0]     idx_calc;
	logic [HIST_W-1:0] hist_next;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid || out_ready);

	assign clr_last = (clr_q == CLRW'(MAXE - 1));
	assign clr_h_ok = ({{(32-CLRW){1'b0}}, clr_q} < 32'(HISTORY_ENTRIES));
	assign clr_c_ok = ({{(32-CLRW){1'b0}}, clr_q} < 32'(COUNTER_ENTRIES));

	// history slot is the shifted address modulo the table size
	assign a_in  = branch_addr >> ADDR_SHIFT;
	assign a_q   = branch_addr_q >> ADDR_SHIFT;
	assign hs_in = (HISTORY_ENTRIES > 1) ? HAW'(a_in) : '0;
	assign hs_q  = (HISTORY_ENTRIES > 1) ? HAW'(a_q) : '0;

	assign hb    = eff_hbits(history_bits_q);
	assign hmask = (HIST_W'(1) << hb) - HIST_W'(1);

	// counter index: history in the low bits, address above; xor mode folds
	// the address into the history bits as well. Stale high history bits
	// (after history_bits was lowered) stay in the concatenated form.
	always_comb begin
		if (xor_mode_q) begin
			idx_full = (({{(32-HIST_W){1'b0}}, h_rdata} ^ a_q) & {{(32-HIST_W){1'b0}}, hmask})
			           | (a_q << hb);
		end else begin
			idx_full = {{(32-HIST_W){1'b0}}, h_rdata} | (a_q << hb);
		end
	end
	assign idx_calc  = idx_full[CW-1:0];
	assign hist_next = {h_rdata[HIST_W-2:0], taken_q} & hmask;

	// history RAM: read on acceptance of a conditional request, written back in the following cycle on update
	always_comb begin
		h_en    = 1'b0;
		h_we    = 1'b0;
		h_addr  = hs_q;
		h_wdata = hist_next;
		unique case (state_q)
			S_CLEAR: begin
				h_en    = clr_h_ok;
				h_we    = 1'b1;
				h_addr  = HAW'(clr_q);
				h_wdata = '0;
			end
			S_IDLE: begin
				h_en   = in_acc && is_conditional;
				h_addr = hs_in;
			end
			S_HIST: begin
				h_en = (cmd_q == CMD_UPDATE);
				h_we = 1'b1;
			end
			S_CTR, S_DONE: begin
				h_en = 1'b0;
			end
			default: begin
				h_en = 1'b0;
			end
		endcase
	end

	// counter RAM: read once the index is known, stepped and written back on update
	always_comb begin
		c_en    = 1'b0;
		c_we    = 1'b0;
		c_addr  = idx_q;
		c_wdata = ctr_step(c_rdata, taken_q);
		unique case (state_q)
			S_CLEAR: begin
				c_en    = clr_c_ok;
				c_we    = 1'b1;
				c_addr  = CW'(clr_q);
				c_wdata = {clr_q[0], ~clr_q[0]};  // even entries 1, odd 2
			end
			S_HIST: begin
				c_en   = 1'b1;
				c_addr = (cmd_q == CMD_LOOKUP) ? idx_calc : CW'(update_index_q);
			end
			S_CTR: begin
				c_en = (cmd_q == CMD_UPDATE);
				c_we = 1'b1;
			end
			S_IDLE, S_DONE: begin
				c_en = 1'b0;
			end
			default: begin
				c_en = 1'b0;
			end
		endcase
	end

	tldp_ram #(
		.WIDTH (HIST_W),
		.DEPTH (HISTORY_ENTRIES)
	) u_hist_ram (
		.clk   (clk),
		.en    (h_en),
		.we    (h_we),
		.addr  (h_addr),
		.wdata (h_wdata),
		.rdata (h_rdata)
	);

	tldp_ram #(
		.WIDTH (CTR_W),
		.DEPTH (COUNTER_ENTRIES)
	) u_ctr_ram (
		.clk   (clk),
		.en    (c_en),
		.we    (c_we),
		.addr  (c_addr),
		.wdata (c_wdata),
		.rdata (c_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_mode_q     <= 1'b0;
			history_bits_q <= HB_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_XOR_MODE:     xor_mode_q     <= cfg_wdata[0];
				CFG_HISTORY_BITS: history_bits_q <= cfg_wdata;
				default:          xor_mode_q     <= xor_mode_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLRW'(1);
					if (clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= is_conditional ? S_HIST : S_DONE;
					end
				end
				S_HIST:  state_q <= S_CTR;
				S_CTR:   state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// request and result holding registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q          <= cmd;
			branch_addr_q  <= branch_addr;
			cond_q         <= is_conditional;
			taken_q        <= taken;
			update_index_q <= update_index;
			// unconditional: taken on lookup, zeros on update
			res_pred_q     <= (cmd == CMD_LOOKUP);
			res_idx_q      <= '0;
		end
		if (state_q == S_HIST) begin
			idx_q <= (cmd_q == CMD_LOOKUP) ? idx_calc : CW'(update_index_q);
		end
		if (state_q == S_CTR) begin
			res_pred_q <= (cmd_q == CMD_LOOKUP) ? c_rdata[1] : 1'b0;
			res_idx_q  <= IDX_W'(idx_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dir_taken     <= res_pred_q;
			counter_index <= res_idx_q;
		end
	end

	// unconditional requests skip both tables
	a_uncond_skip: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !is_conditional |=> state_q == S_DONE)
		else $error("unconditional request entered table access");

	// counter writes only during clearing or on a conditional update
	a_ctr_write: assert property (@(posedge clk) disable iff (!arst_n)
		c_en && c_we |-> state_q == S_CLEAR || (state_q == S_CTR && cmd_q == CMD_UPDATE
		                                         && cond_q))
		else $error("unexpected counter table write");

	// a history write is followed by the counter step of the same update
	a_hist_then_ctr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HIST && h_en && h_we |=> state_q == S_CTR && c_en && c_we)
		else $error("history updated without counter step");

	// nothing is accepted before the clearing pass completes
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !in_ready && !out_valid)
		else $error("request channel active during clearing pass");

endmodule
